// File: rtl/tdpt_pkg.sv
// Shared types and constants for the trial-division prime test.
package tdpt_pkg;

    // Width of the value field on the input port.
    localparam int VALUE_W = 32;

    // Control states of the trial-division sequencer.
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_OUT
    } t_state;

endpackage

// File: rtl/trial_division_prime_test.sv
// Top level of the trial-division prime test: sequencer, divisor counter and result register.
//
//  Channel  | Direction | Handshake           | Payload
//  ---------+-----------+---------------------+-----------------
//  input    | in        | i_valid / o_stall   | i_value[31:0]
//  result   | out       | o_valid / i_stall   | o_is_prime
//
// Values below 4 and even values are decided without a divisor search, then transferred.
// An odd value is divided by each trial divisor 3, 5, 7, ... in turn on the bit-serial
// divider; at most about 2^(WIDTH/2-1) divisors are tried.
// Reset is synchronous and active low; it empties the sequencer and the result register.
// A new value is taken only while the sequencer is idle, even while a result waits.
// A stalled result holds its register; the sequencer waits in its final state until free.
module trial_division_prime_test #(
    parameter int WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [tdpt_pkg::VALUE_W-1:0] i_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_is_prime
);

    tdpt_pkg::t_state r_state;
    tdpt_pkg::t_state n_state;

    logic [WIDTH-1:0] r_value;
    logic [WIDTH-1:0] r_div;
    logic             r_result;
    logic             r_out_valid;
    logic             r_out_prime;

    logic [WIDTH+tdpt_pkg::VALUE_W-1:0] n_ext;
    logic             in_xfer;
    logic             out_free;
    logic             small_val;
    logic             div_start;
    logic             div_busy;
    logic             div_done;
    logic [WIDTH-1:0] div_quo;
    logic             div_rem_zero;
    logic             past_bound;

    // Zero-extend the incoming value; only its low WIDTH bits are captured.
    assign n_ext = {{WIDTH{1'b0}}, i_value};

    assign in_xfer    = i_valid && (r_state == tdpt_pkg::S_IDLE);
    assign out_free   = !r_out_valid || !i_stall;
    assign small_val  = (r_value < WIDTH'(4)) || !r_value[0];
    assign past_bound = (r_div > div_quo);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            tdpt_pkg::S_IDLE: begin
                if (in_xfer) n_state = tdpt_pkg::S_START;
            end
            tdpt_pkg::S_START: begin
                n_state = small_val ? tdpt_pkg::S_OUT : tdpt_pkg::S_DIV;
            end
            tdpt_pkg::S_DIV: begin
                if (div_done && (past_bound || div_rem_zero)) n_state = tdpt_pkg::S_OUT;
            end
            tdpt_pkg::S_OUT: begin
                if (out_free) n_state = tdpt_pkg::S_IDLE;
            end
            default: n_state = tdpt_pkg::S_IDLE;
        endcase
    end

    // Output logic: handshake and divider launch.
    always_comb begin
        o_stall   = 1'b1;
        div_start = 1'b0;
        case (r_state)
            tdpt_pkg::S_IDLE:  o_stall = 1'b0;
            tdpt_pkg::S_START: div_start = !small_val;
            tdpt_pkg::S_DIV:   div_start = div_done && !past_bound && !div_rem_zero;
            tdpt_pkg::S_OUT:   div_start = 1'b0;
            default:           o_stall = 1'b1;
        endcase
    end

    // Sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdpt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Value capture, divisor stepping and verdict.
    always_ff @(posedge i_clk) begin
        case (r_state)
            tdpt_pkg::S_IDLE: begin
                if (in_xfer) r_value <= n_ext[WIDTH-1:0];
            end
            tdpt_pkg::S_START: begin
                r_div    <= WIDTH'(3);
                r_result <= (r_value == WIDTH'(2)) || (r_value == WIDTH'(3));
            end
            tdpt_pkg::S_DIV: begin
                if (div_done) begin
                    if (past_bound) begin
                        r_result <= 1'b1;
                    end else if (div_rem_zero) begin
                        r_result <= 1'b0;
                    end else begin
                        r_div <= r_div + WIDTH'(2);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Result register; it frees once its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == tdpt_pkg::S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == tdpt_pkg::S_OUT && out_free) r_out_prime <= r_result;
    end

    assign o_valid    = r_out_valid;
    assign o_is_prime = r_out_prime;

    // Remainder unit: value divided by the current trial divisor.
    tdpt_divider #(
        .WIDTH(WIDTH)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_value),
        .i_divisor  (div_start && r_state == tdpt_pkg::S_START ? WIDTH'(3)
                                                               : r_div + WIDTH'(2)),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem_zero (div_rem_zero)
    );

    // A division is launched only when the divider is free.
    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("division launched while the divider is busy");

    // Trial divisors in use are odd and at least three.
    a_div_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tdpt_pkg::S_DIV) |-> (r_div[0] && r_div >= WIDTH'(3)))
        else $error("trial divisor is even or below three");

    // Searching is only done for odd values of at least five.
    a_search_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tdpt_pkg::S_DIV) |-> (r_value[0] && r_value >= WIDTH'(5)))
        else $error("divisor search entered for a value decided at once");

endmodule

// File: rtl/tdpt_divider.sv
// Bit-serial restoring divider that yields one quotient bit per cycle.
module tdpt_divider #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_busy,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quo,
    output logic             o_rem_zero
);

    localparam int CNT_W = $clog2(WIDTH);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_dsr;

    logic [WIDTH:0]   n_shift;
    logic [WIDTH:0]   n_diff;
    logic             n_ge;

    // One restoring step: bring down the next dividend bit and try the subtract.
    always_comb begin
        n_shift = {r_rem, r_quo[WIDTH-1]};
        n_ge    = (n_shift >= {1'b0, r_dsr});
        n_diff  = n_shift - {1'b0, r_dsr};
    end

    // Control: count the steps and flag the cycle after the last one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WIDTH - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend shifts out at the top while quotient bits enter below.
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[WIDTH-1:0] : n_shift[WIDTH-1:0];
            r_quo <= {r_quo[WIDTH-2:0], n_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quo      = r_quo;
    assign o_rem_zero = (r_rem == '0);

    // The last step is always followed by a completion flag.
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == '0) |=> r_done)
        else $error("divider finished its steps without flagging completion");

    // Completion never overlaps a running division.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider flagged completion while still busy");

    // A finished remainder is always below a nonzero divisor.
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_dsr != '0) |-> (r_rem < r_dsr))
        else $error("divider remainder is not below the divisor");

endmodule

// File: test/testbench.sv
// Testbench for the trial-division prime test: directed values, then checked random values.
module testbench;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 76;
    localparam int QUIET_ITEMS   = 20;
    localparam int DRAIN_CYCLES  = 40;
    // The slowest value used here is 1000003, about 500 trial divisors.
    localparam int IDLE_LIMIT    = 100000;
    localparam int DIRECTED_ROWS = 24;

    // Whether a row carries its answer or takes it from the predictor.
    localparam bit TYPED     = 1'b1;
    localparam bit PREDICTED = 1'b0;

    typedef struct packed {
        logic [tdpt_pkg::VALUE_W-1:0] value;
        logic                         typed;
        logic                         is_prime;
    } t_row;

    typedef struct packed {
        logic [tdpt_pkg::VALUE_W-1:0] value;
        logic                         is_prime;
    } t_verdict;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic [tdpt_pkg::VALUE_W-1:0] i_value;
    logic                         o_valid;
    logic                         i_stall = 1'b0;
    logic                         o_is_prime;

    t_verdict    verdict_q[$];
    t_verdict    oldest;
    int          errors = 0;
    int unsigned stall_left = 0;
    int unsigned idle_cycles = 0;
    bit          quiet = 1'b0;

    // Small numbers, squares of primes, extremes and values around the top bit.
    t_row directed_rows [DIRECTED_ROWS] = '{
        '{32'd0,          TYPED,     1'b0},
        '{32'd1,          TYPED,     1'b0},
        '{32'd2,          TYPED,     1'b1},
        '{32'd3,          TYPED,     1'b1},
        '{32'd4,          TYPED,     1'b0},
        '{32'd5,          PREDICTED, 1'b0},
        '{32'd7,          PREDICTED, 1'b0},
        '{32'd9,          PREDICTED, 1'b0},
        '{32'd15,         PREDICTED, 1'b0},
        '{32'd25,         PREDICTED, 1'b0},
        '{32'd49,         PREDICTED, 1'b0},
        '{32'd91,         PREDICTED, 1'b0},
        '{32'd97,         PREDICTED, 1'b0},
        '{32'd121,        PREDICTED, 1'b0},
        '{32'd169,        PREDICTED, 1'b0},
        '{32'd65521,      PREDICTED, 1'b0},
        '{32'd65535,      PREDICTED, 1'b0},
        '{32'd1000003,    PREDICTED, 1'b0},
        '{32'h8000_0000,  TYPED,     1'b0},
        '{32'h8000_0001,  PREDICTED, 1'b0},
        '{32'h5555_5555,  PREDICTED, 1'b0},
        '{32'hAAAA_AAAA,  TYPED,     1'b0},
        '{32'hFFFF_FFFE,  TYPED,     1'b0},
        '{32'hFFFF_FFFF,  TYPED,     1'b0}
    };

    trial_division_prime_test #(
        .WIDTH(tdpt_pkg::VALUE_W)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_value(i_value),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_is_prime(o_is_prime)
    );

    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    // Trial division over odd candidates up to the square root; the whole value is used.
    function automatic logic prime_verdict(input logic [tdpt_pkg::VALUE_W-1:0] value);
        longint unsigned v;
        longint unsigned d;
        v = value;
        if (v < 2)
            return 1'b0;
        if (v < 4)
            return 1'b1;
        if (v % 2 == 0)
            return 1'b0;
        for (d = 3; d <= v / d; d += 2) begin
            if (v % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Mostly small and medium values; large ones always have a small factor so they finish fast.
    function automatic logic [tdpt_pkg::VALUE_W-1:0] random_value();
        int unsigned kind;
        int unsigned factor;
        kind = $urandom_range(99);
        if (kind < 40)
            return $urandom_range(1023);
        if (kind < 65)
            return $urandom_range(65535);
        if (kind < 85)
            return $urandom & 32'hFFFF_FFFE;
        factor = 2 * $urandom_range(6, 1) + 1;
        return factor * $urandom_range(32'hFFFF_FFFF / factor);
    endfunction

    // Offers one value, with an optional gap before it, and records the answer at the transfer.
    task automatic offer_value(input logic [tdpt_pkg::VALUE_W-1:0] value, input logic is_prime,
                               input bit allow_gap);
        int unsigned gap;
        t_verdict    entry;
        gap = 0;
        if (allow_gap && $urandom_range(3) == 0)
            gap = $urandom_range(18, 1);
        if (gap != 0) begin
            i_valid <= 1'b0;
            i_value <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (o_stall);
        entry.value = value;
        entry.is_prime = is_prime;
        verdict_q.push_back(entry);
    endtask

    // Reset, directed table, random values, then drain.
    initial begin
        logic [tdpt_pkg::VALUE_W-1:0] value;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_value <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            offer_value(directed_rows[k].value,
                        directed_rows[k].typed ? directed_rows[k].is_prime
                                               : prime_verdict(directed_rows[k].value),
                        1'b1);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                quiet <= 1'b1;
            value = random_value();
            offer_value(value, prime_verdict(value), n < RANDOM_ITEMS - QUIET_ITEMS);
        end
        i_valid <= 1'b0;

        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Result side: check each transfer against the oldest answer, then drive stall bursts outside the quiet phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: result transfer with nothing pending, actual is_prime %0b",
                             $time, o_is_prime);
                    errors = errors + 1;
                end else begin
                    oldest = verdict_q.pop_front();
                    if (o_is_prime !== oldest.is_prime) begin
                        $display("%0t: is_prime for value %0d: expected %0b, actual %0b",
                                 $time, oldest.value, oldest.is_prime, o_is_prime);
                        errors = errors + 1;
                    end
                end
            end

            if (quiet) begin
                i_stall <= 1'b0;
                stall_left <= 0;
            end else if (stall_left != 0) begin
                i_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end else if ($urandom_range(7) == 0) begin
                i_stall <= 1'b1;
                stall_left <= $urandom_range(17);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: ends the run when no transfer happens on either side for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// File: filelist.f
rtl/tdpt_pkg.sv
rtl/tdpt_divider.sv
rtl/trial_division_prime_test.sv
test/testbench.sv
